/* src/fiscal_code_check_char_unit_macros.svh */
// Assertion macros shared by the fiscal code check character unit.
// Depends on nothing; included by modules that carry assertions.
`ifndef FISCAL_CODE_CHECK_CHAR_UNIT_MACROS_SVH
`define FISCAL_CODE_CHECK_CHAR_UNIT_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define FCC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/fcc_pkg.sv */
// Shared types, constants and the odd-position weight table.
// No dependencies; used by all fcc modules.
package fcc_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [7:0] ASCII_A    = 8'd65;
    localparam logic [7:0] ASCII_Z    = 8'd90;
    localparam logic [7:0] ASCII_0    = 8'd48;
    localparam logic [7:0] ASCII_9    = 8'd57;
    localparam logic [5:0] ALPHA_SIZE = 6'd26;

    localparam logic [3:0] POS_LAST_BODY = 4'd14;
    localparam logic [3:0] POS_CHECK     = 4'd15;

    // classified character on its way from front to back
    typedef struct packed {
        logic [4:0] weight;
        logic       bad;
        logic       last;
        logic       verify;
        logic [7:0] code;
    } item_t;

    function automatic logic [4:0] odd_weight(input logic [4:0] off);
        logic [4:0] w;
        begin
            case (off)
                5'd0:    w = 5'd1;
                5'd1:    w = 5'd0;
                5'd2:    w = 5'd5;
                5'd3:    w = 5'd7;
                5'd4:    w = 5'd9;
                5'd5:    w = 5'd13;
                5'd6:    w = 5'd15;
                5'd7:    w = 5'd17;
                5'd8:    w = 5'd19;
                5'd9:    w = 5'd21;
                5'd10:   w = 5'd2;
                5'd11:   w = 5'd4;
                5'd12:   w = 5'd18;
                5'd13:   w = 5'd20;
                5'd14:   w = 5'd11;
                5'd15:   w = 5'd3;
                5'd16:   w = 5'd6;
                5'd17:   w = 5'd8;
                5'd18:   w = 5'd12;
                5'd19:   w = 5'd14;
                5'd20:   w = 5'd16;
                5'd21:   w = 5'd10;
                5'd22:   w = 5'd22;
                5'd23:   w = 5'd25;
                5'd24:   w = 5'd24;
                5'd25:   w = 5'd23;
                default: w = 5'd0;
            endcase
            return w;
        end
    endfunction

endpackage

/* src/fcc_queue.sv */
// Small flop-based queue of classified items between front and back.
// Depends on fcc_pkg and the assertion macro header.
`include "fiscal_code_check_char_unit_macros.svh"

module fcc_queue #(
    parameter int DEPTH = fcc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  fcc_pkg::item_t push_item,
    output logic          full,
    input  logic          pop,
    output logic          pop_valid,
    output fcc_pkg::item_t pop_item
);
    import fcc_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t              mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_item  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    `FCC_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH), "queue count overflow")
    `FCC_ASSERT_NEXT(a_count_up, do_push && !do_pop, count_reg == $past(count_reg) + 1'b1,
        "queue count missed a push")

endmodule

/* src/fcc_front.sv */
// Front end: takes characters, tracks position, classifies and weighs them.
// Depends on fcc_pkg; feeds fcc_queue.
module fcc_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          verify_mode,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [7:0]    char_code,
    output logic          push,
    output fcc_pkg::item_t push_item,
    input  logic          queue_full
);
    import fcc_pkg::*;

    logic [3:0] pos_reg;
    logic [3:0] pos_next;
    logic       accept;
    logic       digit_pos;
    logic       is_letter;
    logic       is_digit;
    logic       ok;
    logic [4:0] off;
    logic [4:0] weight;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;
    assign push     = accept;

    always_comb
    begin
        digit_pos = pos_reg inside {4'd6, 4'd7, 4'd9, 4'd10, 4'd12, 4'd13, 4'd14};
        is_letter = char_code inside {[ASCII_A:ASCII_Z]};
        is_digit  = char_code inside {[ASCII_0:ASCII_9]};
        ok        = digit_pos ? is_digit : is_letter;
        off       = digit_pos ? 5'(char_code - ASCII_0) : 5'(char_code - ASCII_A);
        weight    = '0;
        if (ok && pos_reg != POS_CHECK)
        begin
            weight = pos_reg[0] ? off : odd_weight(off);
        end

        push_item.weight = weight;
        push_item.bad    = !ok;
        push_item.code   = char_code;
        push_item.last   = (pos_reg == POS_CHECK) || (pos_reg == POS_LAST_BODY && !verify_mode);
        push_item.verify = (pos_reg == POS_CHECK);

        if (pos_reg == POS_CHECK)
        begin
            pos_next = '0;
        end
        else if (pos_reg == POS_LAST_BODY)
        begin
            pos_next = verify_mode ? POS_CHECK : '0;
        end
        else
        begin
            pos_next = pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

/* src/fcc_back.sv */
// Back end: accumulates weights mod 26, tracks format errors, registers results.
// Depends on fcc_pkg and the assertion macro header; fed by fcc_queue.
`include "fiscal_code_check_char_unit_macros.svh"

module fcc_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    input  fcc_pkg::item_t item,
    output logic          item_pop,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [6:0]    check_char,
    output logic          format_ok,
    output logic          check_match
);
    import fcc_pkg::*;

    logic [4:0] sum_reg;
    logic [4:0] sum_next;
    logic       err_reg;
    logic       err_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [6:0] check_char_reg;
    logic [6:0] check_char_next;
    logic       format_ok_reg;
    logic       format_ok_next;
    logic       check_match_reg;
    logic       check_match_next;
    logic [5:0] sum_raw;
    logic [4:0] sum_mod;
    logic       err_upd;
    logic [6:0] letter;
    logic       out_free;

    assign out_free = !out_valid_reg || !out_stall;
    assign item_pop = item_valid && (!item.last || out_free);

    always_comb
    begin
        sum_raw = {1'b0, sum_reg} + {1'b0, item.weight};
        sum_mod = (sum_raw >= ALPHA_SIZE) ? 5'(sum_raw - ALPHA_SIZE) : sum_raw[4:0];
        err_upd = err_reg || item.bad;
        letter  = err_upd ? 7'd0 : 7'(ASCII_A) + {2'b00, sum_mod};

        sum_next         = sum_reg;
        err_next         = err_reg;
        out_valid_next   = out_valid_reg && out_stall;
        check_char_next  = check_char_reg;
        format_ok_next   = format_ok_reg;
        check_match_next = check_match_reg;

        if (item_pop)
        begin
            if (item.last)
            begin
                sum_next         = '0;
                err_next         = 1'b0;
                out_valid_next   = 1'b1;
                check_char_next  = letter;
                format_ok_next   = !err_upd;
                check_match_next = item.verify && !err_upd && (item.code == {1'b0, letter});
            end
            else
            begin
                sum_next = sum_mod;
                err_next = err_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg       <= sum_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        check_char_reg  <= check_char_next;
        format_ok_reg   <= format_ok_next;
        check_match_reg <= check_match_next;
    end

    assign out_valid   = out_valid_reg;
    assign check_char  = check_char_reg;
    assign format_ok   = format_ok_reg;
    assign check_match = check_match_reg;

    `FCC_ASSERT_IMPL(a_letter_range, out_valid_reg && format_ok_reg,
        check_char_reg >= 7'(ASCII_A) && check_char_reg <= 7'(ASCII_Z),
        "check letter out of range")
    `FCC_ASSERT_IMPL(a_match_needs_ok, out_valid_reg && check_match_reg, format_ok_reg,
        "match flagged on bad format")

endmodule

/* src/fiscal_code_check_char_unit.sv */
// Fiscal code check character unit: one character per cycle when not stalled;
// the result is registered when the back end pops a code's last character.
// Input stalls only when the two-entry queue fills behind a stalled result.
// rst_n (async, active low) clears position, sum, error flag, queue and
// verify_mode to zero; result payload registers are not reset.
module fiscal_code_check_char_unit #(
    parameter int QUEUE_DEPTH = fcc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_code,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [6:0] check_char,
    output logic       format_ok,
    output logic       check_match
);
    import fcc_pkg::*;

    logic  verify_mode_reg;
    logic  push;
    item_t push_item;
    logic  queue_full;
    logic  pop;
    logic  pop_valid;
    item_t pop_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            verify_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            verify_mode_reg <= cfg_wdata;
        end
    end

    fcc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .verify_mode (verify_mode_reg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .char_code   (char_code),
        .push        (push),
        .push_item   (push_item),
        .queue_full  (queue_full)
    );

    fcc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_item  (pop_item)
    );

    fcc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (pop_valid),
        .item        (pop_item),
        .item_pop    (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .check_char  (check_char),
        .format_ok   (format_ok),
        .check_match (check_match)
    );

endmodule
